/* design/assert_macros.svh */
// Assertion helpers used by the estimator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PRE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PRE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/pre_pkg.sv */
package pre_pkg;

   // defaults for the top-level parameters
   localparam int HISTORY_DEPTH_DEF = 4;
   localparam int SAMPLE_BITS_DEF   = 18;
   localparam int TIME_BITS_DEF     = 32;

   localparam int CFG_BITS       = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int RATE_BITS      = 16;
   localparam int DIVISOR_BITS   = 16;

   // 60000 ms * 256 (Q8.8) needs 24 bits
   localparam int RATE_DIVIDEND_BITS = 24;
   localparam logic [RATE_DIVIDEND_BITS-1:0] RATE_DIVIDEND = 24'd15360000;
   localparam logic [RATE_BITS-1:0] RATE_MAX = 16'hFFFF;

   // baseline EMA: (19*b + x) / 20, peak decay: 49*p / 50
   localparam int BASE_KEEP = 19;
   localparam int PEAK_KEEP = 49;
   localparam logic [DIVISOR_BITS-1:0] BASE_DIVISOR = 16'd20;
   localparam logic [DIVISOR_BITS-1:0] PEAK_DIVISOR = 16'd50;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THR_FLOOR          = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_INTERVAL_MS    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_INTERVAL_MS    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NO_BEAT_TIMEOUT_MS = 2'd3;

   // register reset values
   localparam logic [CFG_BITS-1:0] THR_FLOOR_RST          = 16'd500;
   localparam logic [CFG_BITS-1:0] MIN_INTERVAL_MS_RST    = 16'd300;
   localparam logic [CFG_BITS-1:0] MAX_INTERVAL_MS_RST    = 16'd2000;
   localparam logic [CFG_BITS-1:0] NO_BEAT_TIMEOUT_MS_RST = 16'd3000;

endpackage

/* design/pre_req_if.sv */
interface pre_req_if #(
   parameter int SAMPLE_BITS = pre_pkg::SAMPLE_BITS_DEF,
   parameter int TIME_BITS   = pre_pkg::TIME_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] ir_sample;
   logic [TIME_BITS-1:0]   time_ms;

   modport source (output valid, output ir_sample, output time_ms, input ready);
   modport sink (input valid, input ir_sample, input time_ms, output ready);
endinterface

/* design/pre_rsp_if.sv */
interface pre_rsp_if #(
   parameter int AC_BITS = pre_pkg::SAMPLE_BITS_DEF + 1
);
   logic                          valid;
   logic                          ready;
   logic [pre_pkg::RATE_BITS-1:0] rate_bpm_q8;
   logic                          beat_edge;
   logic                          beat_counted;
   logic                          signal_lost;
   logic [pre_pkg::CFG_BITS-1:0]  detect_level;
   logic signed [AC_BITS-1:0]     ac_level;

   modport source (output valid, output rate_bpm_q8, output beat_edge, output beat_counted,
                   output signal_lost, output detect_level, output ac_level,
                   input ready);
   modport sink (input valid, input rate_bpm_q8, input beat_edge, input beat_counted,
                 input signal_lost, input detect_level, input ac_level,
                 output ready);
endinterface

/* design/pre_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module pre_div #(
   parameter int DIVIDEND_BITS = pre_pkg::RATE_DIVIDEND_BITS,
   parameter int DIVISOR_BITS  = pre_pkg::DIVISOR_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient
);
   localparam int CntBits = $clog2(DIVIDEND_BITS + 1);

   logic [DIVIDEND_BITS-1:0] quo_ff;
   logic [DIVISOR_BITS-1:0]  rem_ff;
   logic [DIVISOR_BITS-1:0]  dvs_ff;
   logic [CntBits-1:0]       cnt_ff;
   logic                     run_ff;
   logic                     done_ff;

   logic [DIVISOR_BITS:0]    trial;
   logic [DIVISOR_BITS:0]    diff;
   logic                     fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CntBits'(DIVIDEND_BITS);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CntBits'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (run_ff) begin
         quo_ff <= {quo_ff[DIVIDEND_BITS-2:0], fits};
         rem_ff <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* design/pulse_rate_estimator_unit.sv */
// Per sample the sequencer updates the baseline (skipped when the first sample seeds it), decays
// the peak, checks for an edge, on a counted beat finds the rate and the history mean, then checks
// for silence. The shared radix-2 divider does every division (baseline, peak, rate and mean).
// A sample is accepted only in idle, after the last result has entered the output register; a
// finished result waits there for the receiver while the next sample is accepted. Reset (synchronous,
// active high) restores register defaults and clears the tracking state but not the history memory.
`include "assert_macros.svh"

module pulse_rate_estimator_unit #(
   parameter int HISTORY_DEPTH = pre_pkg::HISTORY_DEPTH_DEF,
   parameter int SAMPLE_BITS   = pre_pkg::SAMPLE_BITS_DEF,
   parameter int TIME_BITS     = pre_pkg::TIME_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   pre_req_if.sink                             req_if,
   pre_rsp_if.source                           rsp_if,
   input  logic                                csr_wr_en,
   input  logic [pre_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pre_pkg::CFG_BITS-1:0]        csr_wr_data
);
   localparam int RateBits = pre_pkg::RATE_BITS;
   localparam int CfgBits  = pre_pkg::CFG_BITS;
   localparam int DvsBits  = pre_pkg::DIVISOR_BITS;
   localparam int AcBits   = SAMPLE_BITS + 1;
   // peak level never exceeds (2^SAMPLE_BITS - 1) / 50
   localparam int PeakBits = SAMPLE_BITS - 5;
   localparam int ThrBits  = (PeakBits - 1 > CfgBits) ? PeakBits - 1 : CfgBits;
   localparam int CmpBits  = (SAMPLE_BITS > ThrBits) ? SAMPLE_BITS : ThrBits;
   localparam int DivBits  = (SAMPLE_BITS + 5 > pre_pkg::RATE_DIVIDEND_BITS) ?
                             SAMPLE_BITS + 5 : pre_pkg::RATE_DIVIDEND_BITS;
   localparam int IdxBits  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CntBits  = $clog2(HISTORY_DEPTH + 1);
   localparam int SumBits  = RateBits + $clog2(HISTORY_DEPTH);

   // sequencer states
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_BASE      = 4'd1;
   localparam logic [3:0] ST_BASE_WAIT = 4'd2;
   localparam logic [3:0] ST_PEAK      = 4'd3;
   localparam logic [3:0] ST_PEAK_WAIT = 4'd4;
   localparam logic [3:0] ST_EDGE      = 4'd5;
   localparam logic [3:0] ST_RATE_WAIT = 4'd6;
   localparam logic [3:0] ST_MEAN      = 4'd7;
   localparam logic [3:0] ST_MEAN_WAIT = 4'd8;
   localparam logic [3:0] ST_TIMEOUT   = 4'd9;
   localparam logic [3:0] ST_OUT       = 4'd10;

   // configuration registers
   logic [CfgBits-1:0] min_thr_ff;
   logic [CfgBits-1:0] min_iv_ff;
   logic [CfgBits-1:0] max_iv_ff;
   logic [CfgBits-1:0] timeout_ff;

   // sequencer and latched sample
   logic [3:0]             state_ff;
   logic [3:0]             state_in;
   logic [SAMPLE_BITS-1:0] x_ff;
   logic [TIME_BITS-1:0]   now_ff;

   // tracking state
   logic [SAMPLE_BITS-1:0] base_ff;
   logic                   seeded_ff;
   logic [PeakBits-1:0]    peak_ff;
   logic                   was_above_ff;
   logic [TIME_BITS-1:0]   last_ff;
   logic [IdxBits-1:0]     hidx_ff;
   logic [CntBits-1:0]     count_ff;
   logic [SumBits-1:0]     sum_ff;
   logic [RateBits-1:0]    rate_ff;
   logic [RateBits-1:0]    old_ff;
   logic [RateBits-1:0]    hist_mem [HISTORY_DEPTH];

   // per-sample flags
   logic edge_ff;
   logic counted_ff;
   logic lost_ff;

   // result register
   logic                     rsp_valid_ff;
   logic [RateBits-1:0]      rsp_rate_ff;
   logic                     rsp_edge_ff;
   logic                     rsp_counted_ff;
   logic                     rsp_lost_ff;
   logic [CfgBits-1:0]       rsp_thr_ff;
   logic signed [AcBits-1:0] rsp_ac_ff;

   // shared divider
   logic               div_start;
   logic [DivBits-1:0] div_dividend;
   logic [DvsBits-1:0] div_divisor;
   logic               div_done;
   logic [DivBits-1:0] div_quotient;

   // datapath
   logic signed [AcBits-1:0] ac;
   logic signed [AcBits-1:0] ac_neg;
   logic [SAMPLE_BITS-1:0]   mag;
   logic [DivBits-1:0]       base_dividend;
   logic [DivBits-1:0]       peak_scaled;
   logic [DivBits-1:0]       peak_dividend;
   logic [ThrBits-1:0]       half_peak;
   logic [ThrBits-1:0]       thr;
   logic [CfgBits-1:0]       thr_out;
   logic                     above;
   logic                     beat_edge;
   logic [TIME_BITS-1:0]     gap;
   logic                     count_ok;
   logic                     timed_out;
   logic [RateBits-1:0]      rate_sat;
   logic                     hist_full;
   logic [SumBits-1:0]       sum_next;
   logic                     req_fire;
   logic                     out_free;

   assign req_fire = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // AC part and its magnitude
   assign ac     = $signed({1'b0, x_ff}) - $signed({1'b0, base_ff});
   assign ac_neg = -ac;
   assign mag    = ac[AcBits-1] ? ac_neg[SAMPLE_BITS-1:0] : ac[SAMPLE_BITS-1:0];

   // max(floor(49p/50), floor(mag/50)) is floor(max(49p, mag)/50): one division
   assign base_dividend = DivBits'(base_ff) * DivBits'(pre_pkg::BASE_KEEP) + DivBits'(x_ff);
   assign peak_scaled   = DivBits'(peak_ff) * DivBits'(pre_pkg::PEAK_KEEP);
   assign peak_dividend = (peak_scaled > DivBits'(mag)) ? peak_scaled : DivBits'(mag);

   // adaptive threshold, floored by the register
   assign half_peak = ThrBits'(peak_ff[PeakBits-1:1]);
   assign thr       = (half_peak > ThrBits'(min_thr_ff)) ? half_peak : ThrBits'(min_thr_ff);
   assign thr_out   = (thr > ThrBits'(pre_pkg::RATE_MAX)) ? pre_pkg::RATE_MAX
                                                          : thr[CfgBits-1:0];
   assign above     = !ac[AcBits-1] && (CmpBits'(ac[SAMPLE_BITS-1:0]) > CmpBits'(thr));
   assign beat_edge = above && !was_above_ff;

   // time since the last beat; after the edge step this uses the updated last beat
   assign gap       = now_ff - last_ff;
   assign count_ok  = beat_edge && (last_ff != '0) && (gap > TIME_BITS'(min_iv_ff)) &&
                      (gap < TIME_BITS'(max_iv_ff));
   assign timed_out = (last_ff != '0) && (gap > TIME_BITS'(timeout_ff));

   assign rate_sat  = (div_quotient > DivBits'(pre_pkg::RATE_MAX)) ? pre_pkg::RATE_MAX
                                                                   : div_quotient[RateBits-1:0];
   assign hist_full = count_ff == CntBits'(HISTORY_DEPTH);
   // running sum of the valid entries; drop the overwritten one when full
   assign sum_next  = hist_full ? sum_ff - SumBits'(old_ff) + SumBits'(rate_sat)
                                : sum_ff + SumBits'(rate_sat);

   // sequencer and divider operand selection
   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      div_dividend = base_dividend;
      div_divisor  = pre_pkg::BASE_DIVISOR;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            if (seeded_ff) begin
               div_start = 1'b1;
               state_in  = ST_BASE_WAIT;
            end else begin
               state_in  = ST_PEAK;
            end
         end
         ST_BASE_WAIT: begin
            if (div_done) begin
               state_in = ST_PEAK;
            end
         end
         ST_PEAK: begin
            div_start    = 1'b1;
            div_dividend = peak_dividend;
            div_divisor  = pre_pkg::PEAK_DIVISOR;
            state_in     = ST_PEAK_WAIT;
         end
         ST_PEAK_WAIT: begin
            if (div_done) begin
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            div_dividend = DivBits'(pre_pkg::RATE_DIVIDEND);
            div_divisor  = gap[DvsBits-1:0];
            if (count_ok) begin
               div_start = 1'b1;
               state_in  = ST_RATE_WAIT;
            end else begin
               state_in  = ST_TIMEOUT;
            end
         end
         ST_RATE_WAIT: begin
            if (div_done) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            div_start    = 1'b1;
            div_dividend = DivBits'(sum_ff);
            div_divisor  = DvsBits'(count_ff);
            state_in     = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (div_done) begin
               state_in = ST_TIMEOUT;
            end
         end
         ST_TIMEOUT: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   pre_div #(
      .DIVIDEND_BITS(DivBits),
      .DIVISOR_BITS (DvsBits)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_quotient)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_thr_ff <= pre_pkg::THR_FLOOR_RST;
         min_iv_ff  <= pre_pkg::MIN_INTERVAL_MS_RST;
         max_iv_ff  <= pre_pkg::MAX_INTERVAL_MS_RST;
         timeout_ff <= pre_pkg::NO_BEAT_TIMEOUT_MS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            pre_pkg::CSR_THR_FLOOR:          min_thr_ff <= csr_wr_data;
            pre_pkg::CSR_MIN_INTERVAL_MS:    min_iv_ff  <= csr_wr_data;
            pre_pkg::CSR_MAX_INTERVAL_MS:    max_iv_ff  <= csr_wr_data;
            pre_pkg::CSR_NO_BEAT_TIMEOUT_MS: timeout_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // control and tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         seeded_ff    <= 1'b0;
         peak_ff      <= '0;
         was_above_ff <= 1'b0;
         last_ff      <= '0;
         hidx_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rate_ff      <= '0;
         edge_ff      <= 1'b0;
         counted_ff   <= 1'b0;
         lost_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_BASE: begin
               // the first sample seeds the baseline
               if (!seeded_ff) begin
                  base_ff   <= x_ff;
                  seeded_ff <= 1'b1;
               end
            end
            ST_BASE_WAIT: begin
               if (div_done) begin
                  base_ff <= div_quotient[SAMPLE_BITS-1:0];
               end
            end
            ST_PEAK_WAIT: begin
               if (div_done) begin
                  peak_ff <= div_quotient[PeakBits-1:0];
               end
            end
            ST_EDGE: begin
               edge_ff      <= beat_edge;
               counted_ff   <= count_ok;
               was_above_ff <= above;
               if (beat_edge) begin
                  last_ff <= now_ff;
               end
            end
            ST_RATE_WAIT: begin
               if (div_done) begin
                  sum_ff  <= sum_next;
                  hidx_ff <= (hidx_ff == IdxBits'(HISTORY_DEPTH - 1)) ? '0 : hidx_ff + 1'b1;
                  if (!hist_full) begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end
            ST_MEAN_WAIT: begin
               if (div_done) begin
                  rate_ff <= div_quotient[RateBits-1:0];
               end
            end
            ST_TIMEOUT: begin
               // a long silence drops the rate and the whole history
               lost_ff <= timed_out;
               if (timed_out) begin
                  last_ff  <= '0;
                  hidx_ff  <= '0;
                  count_ff <= '0;
                  sum_ff   <= '0;
                  rate_ff  <= '0;
               end
            end
            default: ;
         endcase

         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff   <= req_if.ir_sample;
         now_ff <= req_if.time_ms;
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_rate_ff    <= rate_ff;
         rsp_edge_ff    <= edge_ff;
         rsp_counted_ff <= counted_ff;
         rsp_lost_ff    <= lost_ff;
         rsp_thr_ff     <= thr_out;
         rsp_ac_ff      <= ac;
      end
   end

   // history store: fetch the entry about to be overwritten, then write the new rate
   always_ff @(posedge clock) begin
      if (state_ff == ST_EDGE) begin
         old_ff <= hist_mem[hidx_ff];
      end
      if (state_ff == ST_RATE_WAIT && div_done) begin
         hist_mem[hidx_ff] <= rate_sat;
      end
   end

   assign req_if.ready          = state_ff == ST_IDLE;
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.rate_bpm_q8    = rsp_rate_ff;
   assign rsp_if.beat_edge      = rsp_edge_ff;
   assign rsp_if.beat_counted   = rsp_counted_ff;
   assign rsp_if.signal_lost    = rsp_lost_ff;
   assign rsp_if.detect_level   = rsp_thr_ff;
   assign rsp_if.ac_level       = rsp_ac_ff;

   // a counted beat is always an edge and always leaves a nonzero rate
   `PRE_ASSERT_IMP(a_counted_is_edge, clock, reset, rsp_valid_ff && rsp_counted_ff, rsp_edge_ff, "counted beat without an edge")
   `PRE_ASSERT_IMP(a_counted_rate, clock, reset, rsp_valid_ff && rsp_counted_ff, rsp_rate_ff != '0, "counted beat with zero rate")
   // a timeout must report an unknown rate
   `PRE_ASSERT_IMP(a_lost_clears, clock, reset, rsp_valid_ff && rsp_lost_ff, rsp_rate_ff == '0, "signal lost with a rate")
   // the fill count saturates at the history depth
   `PRE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CntBits'(HISTORY_DEPTH), "history count overflow")
   // an accepted item starts the sequencer
   `PRE_ASSERT_NXT(a_accept_busy, clock, reset, req_fire, state_ff != ST_IDLE, "sequencer did not start")
endmodule

/* tb/sv/tb_pulse_rate_estimator_unit.sv */
`timescale 1ns / 1ps

module tb_pulse_rate_estimator_unit;

   localparam int SAMPLE_W = pre_pkg::SAMPLE_BITS_DEF;
   localparam int TIME_W = pre_pkg::TIME_BITS_DEF;
   localparam int AC_W = pre_pkg::SAMPLE_BITS_DEF + 1;
   localparam int HIST_DEPTH = pre_pkg::HISTORY_DEPTH_DEF;
   localparam int RATE_W = pre_pkg::RATE_BITS;
   localparam int CFG_W = pre_pkg::CFG_BITS;
   localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_W) - 1;
   // 60000 ms per minute, scaled to Q8.8
   localparam int unsigned MS_PER_MIN_Q8 = 60000 * 256;

   typedef struct {
      logic [RATE_W-1:0] rate_bpm_q8;
      logic              beat_edge;
      logic              beat_counted;
      logic              signal_lost;
      logic [CFG_W-1:0]  detect_level;
      logic [AC_W-1:0]   ac_level;
   } pulse_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                               csr_wr_en = 1'b0;
   logic [pre_pkg::CSR_INDEX_BITS-1:0] csr_index = pre_pkg::CSR_THR_FLOOR;
   logic [CFG_W-1:0]                   csr_wr_data = '0;

   pre_req_if req_ch ();
   pre_rsp_if rsp_ch ();

   pulse_rate_estimator_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Clock: 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Drive every input to a known value before the first edge.
   initial begin
      req_ch.valid = 1'b0;
      req_ch.ir_sample = '0;
      req_ch.time_ms = '0;
      rsp_ch.ready = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predicted state of the estimator and its register copy.
   // ---------------------------------------------------------------------
   int unsigned thr_floor = 32'(pre_pkg::THR_FLOOR_RST);
   int unsigned interval_min = 32'(pre_pkg::MIN_INTERVAL_MS_RST);
   int unsigned interval_max = 32'(pre_pkg::MAX_INTERVAL_MS_RST);
   int unsigned silence_limit = 32'(pre_pkg::NO_BEAT_TIMEOUT_MS_RST);

   int unsigned base_level = 0;
   bit          seeded = 1'b0;
   int unsigned crest_level = 0;
   bit          was_high = 1'b0;
   logic [TIME_W-1:0] last_beat_ms = '0;
   int unsigned beat_history [HIST_DEPTH];
   int unsigned history_slot = 0;
   int unsigned history_fill = 0;
   int unsigned mean_rate = 0;

   pulse_result_type pending_results [$];

   // Bookkeeping shared by the stimulus, the receiver and the checker.
   int unsigned sent_count = 0;
   int unsigned fail_count = 0;
   int unsigned edge_total = 0;
   int unsigned counted_total = 0;
   int unsigned lost_total = 0;
   int unsigned setting_total = 0;
   int unsigned stall_hold = 0;
   int unsigned rx_wait = 0;
   bit          steady = 1'b0;
   logic [TIME_W-1:0] clock_ms = 32'd20000;

   // Advance the predicted estimator by one sample and return its result.
   function automatic pulse_result_type track_pulse(input logic [SAMPLE_W-1:0] ir,
                                                    input logic [TIME_W-1:0] now_ms);
      pulse_result_type r;
      int          ac;
      int unsigned mag, decayed, fresh, thr, interval, beat_rate, sum;
      bit          above;
      r = '{default: '0};
      // The first sample seeds the baseline, even when it is zero.
      if (!seeded) begin
         base_level = 32'(ir);
         seeded = 1'b1;
      end else begin
         base_level = (19 * base_level + 32'(ir)) / 20;
      end
      ac = int'(ir) - int'(base_level);
      mag = (ac < 0) ? -ac : ac;
      decayed = (crest_level * 49) / 50;
      fresh = mag / 50;
      crest_level = (decayed > fresh) ? decayed : fresh;
      thr = crest_level / 2;
      if (thr < thr_floor) thr = thr_floor;
      above = (ac > int'(thr));

      if (above && !was_high) begin
         interval = now_ms - last_beat_ms;
         r.beat_edge = 1'b1;
         // A zero timestamp means no beat yet; both bounds are exclusive.
         if (last_beat_ms != 0 && interval > interval_min && interval < interval_max) begin
            beat_rate = MS_PER_MIN_Q8 / interval;
            if (beat_rate > 65535) beat_rate = 65535;
            beat_history[history_slot] = beat_rate;
            history_slot = (history_slot + 1) % HIST_DEPTH;
            if (history_fill < HIST_DEPTH) history_fill++;
            sum = 0;
            for (int i = 0; i < history_fill; i++) sum += beat_history[i];
            mean_rate = sum / history_fill;
            r.beat_counted = 1'b1;
         end
         last_beat_ms = now_ms;
      end
      was_high = above;

      // Silence check runs after the crossing logic.
      if (last_beat_ms != 0 && TIME_W'(now_ms - last_beat_ms) > silence_limit) begin
         last_beat_ms = '0;
         history_fill = 0;
         history_slot = 0;
         mean_rate = 0;
         r.signal_lost = 1'b1;
      end

      r.rate_bpm_q8 = mean_rate[RATE_W-1:0];
      r.detect_level = thr[CFG_W-1:0];
      r.ac_level = ac[AC_W-1:0];
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one sample; return at the edge that accepts it, valid still high.
   task automatic offer_sample(input logic [SAMPLE_W-1:0] ir, input logic [TIME_W-1:0] stamp);
      int unsigned gap;
      gap = steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.ir_sample <= ir;
      req_ch.time_ms <= stamp;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_results.push_back(track_pulse(ir, stamp));
      sent_count++;
   endtask

   // Drop valid and hold until every predicted result has come back.
   task automatic wait_drained();
      if (req_ch.valid !== 1'b0) req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stalls, steady stretches, and a long hold on request.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_hold != 0) begin
         stall_hold--;
         rsp_ch.ready <= 1'b0;
      end else if (steady) begin
         rsp_ch.ready <= 1'b1;
      end else if (rx_wait != 0) begin
         rx_wait--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rx_wait = pick_gap();
         rsp_ch.ready <= (rx_wait == 0);
      end
   end

   // Checker: match each accepted result against the oldest prediction.
   always @(posedge clock) begin : check_results
      pulse_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got rate %0h ac %0h",
                     $time, rsp_ch.rate_bpm_q8, rsp_ch.ac_level);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("rate_bpm_q8", want.rate_bpm_q8, rsp_ch.rate_bpm_q8);
            compare_field("beat_edge", want.beat_edge, rsp_ch.beat_edge);
            compare_field("beat_counted", want.beat_counted, rsp_ch.beat_counted);
            compare_field("signal_lost", want.signal_lost, rsp_ch.signal_lost);
            compare_field("detect_level", want.detect_level, rsp_ch.detect_level);
            compare_field("ac_level", want.ac_level, $unsigned(rsp_ch.ac_level));
            edge_total += want.beat_edge;
            counted_total += want.beat_counted;
            lost_total += want.signal_lost;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Directed samples at the register defaults: full-scale swings so every
   // high sample crosses the threshold and every low one falls back.
   // ---------------------------------------------------------------------
   task automatic test_directed_cases();
      // Crest times: first beat has no predecessor, then intervals of 600,
      // exactly the lower bound, exactly the upper bound, then enough beats
      // to wrap the history ring.
      int unsigned crest_ms [8] = '{600, 1200, 1500, 3500, 4100, 4700, 5300, 5900};
      // A zero first sample seeds the baseline; later zeros must not reseed.
      offer_sample('0, 32'd5);
      foreach (crest_ms[i]) begin
         offer_sample('0, crest_ms[i] - 100);
         offer_sample(SAMPLE_W'(SAMPLE_MAX), crest_ms[i]);
      end
      // Silence past the timeout clears rate and history.
      offer_sample('0, 32'd9000);
      // A crossing at time zero leaves no beat recorded, so the next one is
      // not counted either; the third crossing is counted again.
      offer_sample('0, 32'hFFFF_FF00);
      offer_sample(SAMPLE_W'(SAMPLE_MAX), 32'h0000_0000);
      offer_sample('0, 32'h0000_0100);
      offer_sample(SAMPLE_W'(SAMPLE_MAX), 32'h0000_0300);
      offer_sample('0, 32'h0000_0400);
      offer_sample(SAMPLE_W'(SAMPLE_MAX), 32'h0000_0700);
   endtask

   // Hold the receiver off for a long stretch while samples keep coming, so
   // the block fills and stalls its input; then pause until it drains.
   task automatic test_backpressure();
      wait_drained();
      stall_hold = 400;
      steady = 1'b1;
      repeat (8) begin
         clock_ms += $urandom_range(10, 50);
         offer_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), clock_ms);
      end
      steady = 1'b0;
      wait_drained();
   endtask

   // Write all four registers while idle, then run pulse trains with random
   // shape mixed with noise bursts and clock jumps (silences and wraps).
   task automatic test_random_settings(input logic [CFG_W-1:0] thr_cfg,
                                       input logic [CFG_W-1:0] min_cfg,
                                       input logic [CFG_W-1:0] max_cfg,
                                       input logic [CFG_W-1:0] silence_cfg,
                                       input int unsigned quota);
      int unsigned first, pick, amp, level, noise, period, spacing, beats, width, span;
      logic [SAMPLE_W-1:0] ir;
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_index <= pre_pkg::CSR_THR_FLOOR;
      csr_wr_data <= thr_cfg;
      @(posedge clock);
      csr_index <= pre_pkg::CSR_MIN_INTERVAL_MS;
      csr_wr_data <= min_cfg;
      @(posedge clock);
      csr_index <= pre_pkg::CSR_MAX_INTERVAL_MS;
      csr_wr_data <= max_cfg;
      @(posedge clock);
      csr_index <= pre_pkg::CSR_NO_BEAT_TIMEOUT_MS;
      csr_wr_data <= silence_cfg;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      thr_floor = 32'(thr_cfg);
      interval_min = 32'(min_cfg);
      interval_max = 32'(max_cfg);
      silence_limit = 32'(silence_cfg);
      setting_total++;

      first = sent_count;
      while (sent_count - first < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            // Pulse train: a short crest per beat on top of a flat level.
            amp = ($urandom_range(0, 9) == 0) ? $urandom_range(60000, 120000)
                                              : $urandom_range(300, 30000);
            noise = amp / 8 + 1;
            level = $urandom_range(0, SAMPLE_MAX - amp - noise);
            period = $urandom_range(250, 2300);
            spacing = $urandom_range(period / 12 + 1, period / 3);
            width = $urandom_range(1, 2);
            beats = $urandom_range(2, 8);
            steady = ($urandom_range(0, 4) == 0);
            repeat (beats) begin
               span = period + $urandom_range(0, period / 10);
               for (int s = 0; s * spacing < span; s++) begin
                  ir = SAMPLE_W'(level + ((s < width) ? amp : 0) + $urandom_range(0, noise));
                  offer_sample(ir, clock_ms);
                  clock_ms += spacing;
               end
            end
            steady = 1'b0;
         end else if (pick < 90) begin
            // Noise burst over the full sample range.
            repeat ($urandom_range(1, 10)) begin
               clock_ms += $urandom_range(0, 400);
               offer_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), clock_ms);
            end
         end else begin
            // Break the sequence: random clock, a wrap ahead, or a silence.
            pick = $urandom_range(0, 3);
            if (pick == 0) clock_ms = $urandom();
            else if (pick == 1) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            else clock_ms += $urandom_range(2000, 70000);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_backpressure();
      // Defaults written back explicitly, then the extremes both ways: the
      // second one has min >= max so nothing counts and a zero timeout.
      test_random_settings(pre_pkg::THR_FLOOR_RST, pre_pkg::MIN_INTERVAL_MS_RST,
                           pre_pkg::MAX_INTERVAL_MS_RST, pre_pkg::NO_BEAT_TIMEOUT_MS_RST, 300);
      test_random_settings(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 250);
      test_random_settings(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 200);
      test_random_settings(CFG_W'($urandom_range(100, 3000)), CFG_W'($urandom_range(150, 450)),
                           CFG_W'($urandom_range(1200, 2600)),
                           CFG_W'($urandom_range(1500, 5000)), 300);
      // Equal bounds: no interval can fall strictly between them.
      begin : equal_bounds
         logic [CFG_W-1:0] bound;
         bound = CFG_W'($urandom_range(300, 1500));
         test_random_settings(16'h0000, bound, bound, CFG_W'($urandom_range(2000, 6000)), 250);
      end

      // Drain, then give the block time to emit anything stray.
      wait_drained();
      repeat (200) @(posedge clock);
      $display("Sent %0d samples over %0d register settings plus defaults.",
               sent_count, setting_total);
      $display("Saw %0d beat edges, %0d counted beats and %0d signal losses.",
               edge_total, counted_total, lost_total);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog: several times the slowest correct run.
   initial begin
      #12_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
